>>> hw/rtl/cap_pkg.sv
// Shared types and constants of the crossover allpass coefficient designer.
// No dependencies; cap_cordic and the top level take names from here by scoped reference.
`default_nettype none

package cap_pkg;

  localparam int FREQ_W = 17;
  localparam int SR_W   = 18;
  localparam int COEF_W = 32;
  localparam int ANG_W  = 32;
  localparam int XY_W   = 34;        // CORDIC x/y, Q30 with headroom
  localparam int Z_W    = 33;        // residual angle, signed turns
  localparam int ND_W   = XY_W + 1;  // numerator, denominator, d
  localparam int E_W    = 34;        // 2^F - c2
  localparam int PROD_W = ND_W + E_W;
  localparam int Q_BITS = 32;        // quotient bits of both dividers

  localparam int LANES    = 3;
  localparam int LANE_COS = 0;
  localparam int LANE_C2  = 1;
  localparam int LANE_C1  = 2;

  localparam logic [SR_W-1:0]          SR_RESET   = 18'd48000;
  localparam logic [ANG_W-1:0]         INV_Q_HALF = 32'd3037000500;
  localparam logic signed [XY_W-1:0]   INV_GAIN   = 34'sd652032874;
  localparam logic signed [COEF_W-1:0] COEF_MAX   = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN   = 32'sh8000_0000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // arctangent of 2^-i in Q0.32 turns
  localparam logic [ANG_W-1:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0]  z_t;
  typedef logic signed [ND_W-1:0] nd_t;

  typedef struct packed {
    logic neg;      // quotient takes a negative sign
    logic den_pos;  // denominator strictly positive
    logic ovf;      // quotient does not fit Q_BITS
  } coef_flags_t;

  typedef struct packed {
    logic        vld;
    nd_t         d;
    coef_flags_t fl;
  } c2_side_t;

endpackage

`default_nettype wire

>>> hw/rtl/cap_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side-band pipe.
// Depends on nothing but its parameters; the caller guarantees rem_i < den_i.
`default_nettype none

module cap_div #(
  parameter int DW = 35,
  parameter int QB = 32,
  parameter int SW = 1
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           en,
  input  wire [DW-1:0]  rem_i,
  input  wire [DW-1:0]  den_i,
  input  wire [QB-1:0]  low_i,
  input  wire [SW-1:0]  side_i,
  output logic [QB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_r   [QB];
  logic [DW-1:0] den_r   [QB];
  logic [QB-1:0] low_r   [QB];
  logic [QB-1:0] quo_r   [QB];
  logic [SW-1:0] side_r  [QB];

  logic [DW-1:0] rem_in  [QB];
  logic [DW-1:0] den_in  [QB];
  logic [QB-1:0] low_in  [QB];
  logic [QB-1:0] quo_in  [QB];
  logic [DW:0]   trial_w [QB];
  logic          ge_w    [QB];
  logic [DW-1:0] rem_nxt [QB];
  logic [QB-1:0] low_nxt [QB];
  logic [QB-1:0] quo_nxt [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        rem_in[k] = rem_i;
        den_in[k] = den_i;
        low_in[k] = low_i;
        quo_in[k] = '0;
      end else begin
        rem_in[k] = rem_r[k-1];
        den_in[k] = den_r[k-1];
        low_in[k] = low_r[k-1];
        quo_in[k] = quo_r[k-1];
      end
      // bring down the next dividend bit, subtract if it fits
      trial_w[k] = {rem_in[k], low_in[k][QB-1]};
      ge_w[k]    = trial_w[k] >= {1'b0, den_in[k]};
      rem_nxt[k] = ge_w[k] ? DW'(trial_w[k] - {1'b0, den_in[k]}) : DW'(trial_w[k]);
      low_nxt[k] = low_in[k] << 1;
      quo_nxt[k] = {quo_in[k][QB-2:0], ge_w[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) side_r[k] <= '0;
    end else if (en) begin
      for (int k = 0; k < QB; k++) side_r[k] <= (k == 0) ? side_i : side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        den_r[k] <= den_in[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign quo_o  = quo_r[QB-1];
  assign side_o = side_r[QB-1];

endmodule

`default_nettype wire

>>> hw/rtl/cap_cordic.sv
// Pipelined rotation CORDIC, three angle lanes side by side, one stage per iteration.
// Depends on cap_pkg for the arctangent table, widths and quadrant codes.
`default_nettype none

module cap_cordic #(
  parameter int STAGES = 24
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          en,
  input  wire                                          vld_i,
  input  wire [cap_pkg::LANES-1:0][cap_pkg::ANG_W-1:0] ang_i,
  output logic                                         vld_o,
  output logic [cap_pkg::LANES-1:0][cap_pkg::XY_W-1:0] cos_o,
  output logic [cap_pkg::LANES-1:0][cap_pkg::XY_W-1:0] sin_o
);

  localparam int L = cap_pkg::LANES;

  logic [STAGES-1:0] vld_r;
  logic              vld_out_r;
  cap_pkg::xy_t      x_r     [STAGES][L];
  cap_pkg::xy_t      y_r     [STAGES][L];
  cap_pkg::z_t       z_r     [STAGES][L];
  logic [1:0]        quad_r  [STAGES][L];

  cap_pkg::xy_t      x_in    [STAGES][L];
  cap_pkg::xy_t      y_in    [STAGES][L];
  cap_pkg::z_t       z_in    [STAGES][L];
  logic [1:0]        quad_in [STAGES][L];
  cap_pkg::xy_t      x_nxt   [STAGES][L];
  cap_pkg::xy_t      y_nxt   [STAGES][L];
  cap_pkg::z_t       z_nxt   [STAGES][L];

  cap_pkg::xy_t      cos_nxt [L];
  cap_pkg::xy_t      sin_nxt [L];
  cap_pkg::xy_t      cos_r   [L];
  cap_pkg::xy_t      sin_r   [L];

  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < L; l++) begin
        if (s == 0) begin
          x_in[s][l]    = cap_pkg::INV_GAIN;
          y_in[s][l]    = '0;
          z_in[s][l]    = cap_pkg::z_t'(ang_i[l][cap_pkg::ANG_W-3:0]);
          quad_in[s][l] = ang_i[l][cap_pkg::ANG_W-1:cap_pkg::ANG_W-2];
        end else begin
          x_in[s][l]    = x_r[s-1][l];
          y_in[s][l]    = y_r[s-1][l];
          z_in[s][l]    = z_r[s-1][l];
          quad_in[s][l] = quad_r[s-1][l];
        end
        // rotate toward zero residual angle
        if (!z_in[s][l][cap_pkg::Z_W-1]) begin
          x_nxt[s][l] = x_in[s][l] - (y_in[s][l] >>> s);
          y_nxt[s][l] = y_in[s][l] + (x_in[s][l] >>> s);
          z_nxt[s][l] = z_in[s][l] - cap_pkg::z_t'(cap_pkg::ATAN_TURNS[s]);
        end else begin
          x_nxt[s][l] = x_in[s][l] + (y_in[s][l] >>> s);
          y_nxt[s][l] = y_in[s][l] - (x_in[s][l] >>> s);
          z_nxt[s][l] = z_in[s][l] + cap_pkg::z_t'(cap_pkg::ATAN_TURNS[s]);
        end
      end
    end
  end

  // fold the result back into the quadrant taken off the angle
  always_comb begin
    for (int l = 0; l < L; l++) begin
      unique case (quad_r[STAGES-1][l])
        cap_pkg::QUAD_0: begin
          cos_nxt[l] = x_r[STAGES-1][l];
          sin_nxt[l] = y_r[STAGES-1][l];
        end
        cap_pkg::QUAD_1: begin
          cos_nxt[l] = -y_r[STAGES-1][l];
          sin_nxt[l] = x_r[STAGES-1][l];
        end
        cap_pkg::QUAD_2: begin
          cos_nxt[l] = -x_r[STAGES-1][l];
          sin_nxt[l] = -y_r[STAGES-1][l];
        end
        default: begin
          cos_nxt[l] = y_r[STAGES-1][l];
          sin_nxt[l] = -x_r[STAGES-1][l];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[STAGES-2:0], vld_i};
      vld_out_r <= vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        for (int l = 0; l < L; l++) begin
          x_r[s][l]    <= x_nxt[s][l];
          y_r[s][l]    <= y_nxt[s][l];
          z_r[s][l]    <= z_nxt[s][l];
          quad_r[s][l] <= quad_in[s][l];
        end
      end
      for (int l = 0; l < L; l++) begin
        cos_r[l] <= cos_nxt[l];
        sin_r[l] <= sin_nxt[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      cos_o[l] = cos_r[l];
      sin_o[l] = sin_r[l];
    end
  end

  assign vld_o = vld_out_r;

endmodule

`default_nettype wire

>>> hw/rtl/crossover_allpass_coef.sv
// Crossover allpass coefficient designer: top level.
// Uses cap_pkg, cap_div (phase and coefficient dividers) and cap_cordic.
//
// Usage:
//   Write the sample rate in hertz on the cfg channel (cfg_valid/cfg_ready,
//   always ready) while no item is in flight. Send one crossover frequency per
//   item on the in channel; each item returns one result on the out channel with
//   the second-order pair (k1, k2) and the first-order coefficient, all signed
//   with COEF_FRAC_BITS fraction bits.
// Throughput and depth:
//   One item per cycle unless frozen by a stall. An item passes CORDIC_STAGES
//   + 73 register stages: a clamp stage, a 32-stage phase divider, a multiplier
//   stage, the CORDIC iterations plus a quadrant stage, two operand stages, a
//   32-stage coefficient divider, three finishing stages and the output
//   register. The one-bit-per-stage dividers set the bulk of that figure.
// Reset:
//   Reset (rst_n low, synchronous) empties the pipeline, drops out_valid and
//   loads the sample rate register with 48000.
// Stall:
//   The output register holds a waiting result. The pipeline keeps advancing
//   and in_ready stays high until an item reaches the last stage behind a held
//   result; then everything freezes in place, so no item is lost or repeated.
`default_nettype none

module crossover_allpass_coef #(
  parameter int COEF_FRAC_BITS = 30,
  parameter int CORDIC_STAGES  = 24
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [cap_pkg::SR_W-1:0]            cfg_sample_rate_hz,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [cap_pkg::FREQ_W-1:0]          in_cross_freq_hz,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [cap_pkg::COEF_W-1:0]  out_second_order_k1,
  output logic signed [cap_pkg::COEF_W-1:0]  out_second_order_k2,
  output logic signed [cap_pkg::COEF_W-1:0]  out_first_order_k1
);

  localparam int SRW     = cap_pkg::SR_W;
  localparam int FW      = cap_pkg::FREQ_W;
  localparam int CW      = cap_pkg::COEF_W;
  localparam int NDW     = cap_pkg::ND_W;
  localparam int EW      = cap_pkg::E_W;
  localparam int PW      = cap_pkg::PROD_W;
  localparam int QB      = cap_pkg::Q_BITS;
  localparam int AW      = cap_pkg::ANG_W;
  localparam int NUM_W   = NDW + COEF_FRAC_BITS;  // |num| scaled by 2^F
  localparam int D_SHIFT = 30 - COEF_FRAC_BITS;
  localparam int C2_SW   = $bits(cap_pkg::c2_side_t);
  localparam int C1_SW   = $bits(cap_pkg::coef_flags_t);

  localparam logic signed [EW-1:0] ONE_F  = EW'(1) << COEF_FRAC_BITS;
  localparam logic signed [PW-1:0] K1_MAX = PW'(cap_pkg::COEF_MAX);
  localparam logic signed [PW-1:0] K1_MIN = PW'(cap_pkg::COEF_MIN);

  // saturate a quotient magnitude with its sign into the coefficient range
  function automatic logic signed [CW-1:0] coef_sat(input logic [QB-1:0] q,
                                                    input cap_pkg::coef_flags_t fl);
    logic signed [CW-1:0] r;
    if (!fl.den_pos) begin
      r = cap_pkg::COEF_MAX;
    end else if (fl.ovf) begin
      r = fl.neg ? cap_pkg::COEF_MIN : cap_pkg::COEF_MAX;
    end else if (fl.neg) begin
      r = (q > QB'(cap_pkg::COEF_MAX) + QB'(1)) ? cap_pkg::COEF_MIN : -$signed(CW'(q));
    end else begin
      r = q[QB-1] ? cap_pkg::COEF_MAX : $signed(CW'(q));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- control
  logic pipe_en;
  logic out_hold;
  logic out_valid_r;
  logic m_vld_r;

  // freeze only when an item sits in the last stage behind a held result
  assign out_hold  = out_valid_r && !out_ready;
  assign pipe_en   = !(m_vld_r && out_hold);
  assign in_ready  = pipe_en;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- config
  logic [SRW-1:0] sample_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= cap_pkg::SR_RESET;
    end else if (cfg_valid) begin
      sample_rate_r <= cfg_sample_rate_hz;
    end
  end

  // ---------------------------------------------------------------- stage A: clamp
  logic [FW-1:0] half_rate;
  logic [FW-1:0] a_freq_nxt;
  logic [FW-1:0] a_freq_r;
  logic          a_vld_r;

  assign half_rate  = sample_rate_r[SRW-1:1];
  assign a_freq_nxt = (in_cross_freq_hz > half_rate) ? half_rate : in_cross_freq_hz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (pipe_en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) a_freq_r <= a_freq_nxt;
  end

  // ---------------------------------------------------------------- phase divider
  // phase = floor(f * 2^32 / fs); f <= fs/2 keeps the remainder below fs
  logic [SRW-1:0] pdiv_rem;
  logic [QB-1:0]  pdiv_quo;
  logic           pdiv_vld;

  assign pdiv_rem = SRW'(a_freq_r);

  cap_div #(
    .DW(SRW),
    .QB(QB),
    .SW(1)
  ) u_phase_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .rem_i  (pdiv_rem),
    .den_i  (sample_rate_r),
    .low_i  ('0),
    .side_i (a_vld_r),
    .quo_o  (pdiv_quo),
    .side_o (pdiv_vld)
  );

  // ---------------------------------------------------------------- stage B: angles
  logic [AW-1:0]   phase_nxt;
  logic [2*AW-1:0] b_prod_nxt;
  logic [AW-1:0]   b_phase_r;
  logic [2*AW-1:0] b_prod_r;
  logic            b_vld_r;

  // a zero sample rate reads as phase zero
  assign phase_nxt  = (sample_rate_r == '0) ? '0 : AW'(pdiv_quo);
  assign b_prod_nxt = {{AW{1'b0}}, phase_nxt} * {{AW{1'b0}}, cap_pkg::INV_Q_HALF};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (pipe_en) begin
      b_vld_r <= pdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      b_phase_r <= phase_nxt;
      b_prod_r  <= b_prod_nxt;
    end
  end

  // ---------------------------------------------------------------- CORDIC
  logic [cap_pkg::LANES-1:0][AW-1:0]           cordic_ang;
  logic [cap_pkg::LANES-1:0][cap_pkg::XY_W-1:0] cordic_cos;
  logic [cap_pkg::LANES-1:0][cap_pkg::XY_W-1:0] cordic_sin;
  logic                                        cordic_vld;

  always_comb begin
    cordic_ang[cap_pkg::LANE_COS] = b_phase_r;
    cordic_ang[cap_pkg::LANE_C2]  = b_prod_r[2*AW-1:AW];
    cordic_ang[cap_pkg::LANE_C1]  = {1'b0, b_phase_r[AW-1:1]};
  end

  cap_cordic #(
    .STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (pipe_en),
    .vld_i (b_vld_r),
    .ang_i (cordic_ang),
    .vld_o (cordic_vld),
    .cos_o (cordic_cos),
    .sin_o (cordic_sin)
  );

  // ---------------------------------------------------------------- stage N1: num, den, d
  // coefficient lanes: index 0 is the second-order c2, index 1 the first-order c1
  cap_pkg::xy_t co_w [cap_pkg::LANES];
  cap_pkg::xy_t si_w [cap_pkg::LANES];
  cap_pkg::nd_t neg_co;
  cap_pkg::nd_t n1_num_nxt [2];
  cap_pkg::nd_t n1_den_nxt [2];
  cap_pkg::nd_t n1_d_nxt;
  cap_pkg::nd_t n1_num_r   [2];
  cap_pkg::nd_t n1_den_r   [2];
  cap_pkg::nd_t n1_d_r;
  logic         n1_vld_r;

  always_comb begin
    for (int l = 0; l < cap_pkg::LANES; l++) begin
      co_w[l] = cap_pkg::xy_t'(cordic_cos[l]);
      si_w[l] = cap_pkg::xy_t'(cordic_sin[l]);
    end
    for (int k = 0; k < 2; k++) begin
      n1_num_nxt[k] = cap_pkg::nd_t'(si_w[k+1]) - cap_pkg::nd_t'(co_w[k+1]);
      n1_den_nxt[k] = cap_pkg::nd_t'(si_w[k+1]) + cap_pkg::nd_t'(co_w[k+1]);
    end
    neg_co   = -cap_pkg::nd_t'(co_w[cap_pkg::LANE_COS]);
    n1_d_nxt = neg_co >>> D_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      n1_vld_r <= cordic_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 2; k++) begin
        n1_num_r[k] <= n1_num_nxt[k];
        n1_den_r[k] <= n1_den_nxt[k];
      end
      n1_d_r <= n1_d_nxt;
    end
  end

  // ---------------------------------------------------------------- stage N2: magnitude
  logic [NDW-1:0] n2_mag_r  [2];
  logic [NDW-1:0] n2_den_r  [2];
  logic           n2_neg_r  [2];
  logic           n2_dpos_r [2];
  cap_pkg::nd_t   n2_d_r;
  logic           n2_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      n2_vld_r <= n1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 2; k++) begin
        n2_neg_r[k]  <= n1_num_r[k][NDW-1];
        n2_mag_r[k]  <= n1_num_r[k][NDW-1] ? NDW'(-n1_num_r[k]) : NDW'(n1_num_r[k]);
        n2_den_r[k]  <= NDW'(n1_den_r[k]);
        n2_dpos_r[k] <= !n1_den_r[k][NDW-1] && (n1_den_r[k] != '0);
      end
      n2_d_r <= n1_d_r;
    end
  end

  // ---------------------------------------------------------------- coefficient dividers
  logic [NUM_W-1:0]    num_sh  [2];
  logic [NDW-1:0]      rem0    [2];
  logic [QB-1:0]       low0    [2];
  cap_pkg::coef_flags_t flags  [2];
  cap_pkg::c2_side_t   c2_side_in;
  cap_pkg::c2_side_t   c2_side_out;
  cap_pkg::coef_flags_t c1_side_out;
  logic [QB-1:0]       c2_quo;
  logic [QB-1:0]       c1_quo;

  // top quotient bits beyond QB are caught up front: overflow when the high
  // part of the scaled numerator already reaches the denominator
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      num_sh[k]        = NUM_W'(n2_mag_r[k]) << COEF_FRAC_BITS;
      rem0[k]          = NDW'(num_sh[k] >> QB);
      low0[k]          = num_sh[k][QB-1:0];
      flags[k].neg     = n2_neg_r[k];
      flags[k].den_pos = n2_dpos_r[k];
      flags[k].ovf     = rem0[k] >= n2_den_r[k];
    end
    c2_side_in.vld = n2_vld_r;
    c2_side_in.d   = n2_d_r;
    c2_side_in.fl  = flags[0];
  end

  cap_div #(
    .DW(NDW),
    .QB(QB),
    .SW(C2_SW)
  ) u_c2_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .rem_i  (rem0[0]),
    .den_i  (n2_den_r[0]),
    .low_i  (low0[0]),
    .side_i (c2_side_in),
    .quo_o  (c2_quo),
    .side_o (c2_side_out)
  );

  cap_div #(
    .DW(NDW),
    .QB(QB),
    .SW(C1_SW)
  ) u_c1_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .rem_i  (rem0[1]),
    .den_i  (n2_den_r[1]),
    .low_i  (low0[1]),
    .side_i (flags[1]),
    .quo_o  (c1_quo),
    .side_o (c1_side_out)
  );

  // ---------------------------------------------------------------- stage S: saturate c
  logic signed [CW-1:0] s_c2_r;
  logic signed [CW-1:0] s_c1_r;
  cap_pkg::nd_t         s_d_r;
  logic                 s_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s_vld_r <= c2_side_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s_c2_r <= coef_sat(c2_quo, c2_side_out.fl);
      s_c1_r <= coef_sat(c1_quo, c1_side_out);
      s_d_r  <= c2_side_out.d;
    end
  end

  // ---------------------------------------------------------------- stage T: 1 - c2, -c2
  logic signed [EW-1:0] t_e_r;
  logic signed [CW-1:0] t_k2_r;
  logic signed [CW-1:0] t_c1_r;
  cap_pkg::nd_t         t_d_r;
  logic                 t_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (pipe_en) begin
      t_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      t_e_r  <= ONE_F - EW'(s_c2_r);
      t_k2_r <= (s_c2_r == cap_pkg::COEF_MIN) ? cap_pkg::COEF_MAX : -s_c2_r;
      t_c1_r <= s_c1_r;
      t_d_r  <= s_d_r;
    end
  end

  // ---------------------------------------------------------------- stage M: d * (1 - c2)
  logic signed [PW-1:0] m_prod_r;
  logic signed [CW-1:0] m_k2_r;
  logic signed [CW-1:0] m_c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m_vld_r <= t_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_prod_r <= t_d_r * t_e_r;
      m_k2_r   <= t_k2_r;
      m_c1_r   <= t_c1_r;
    end
  end

  // ---------------------------------------------------------------- output register
  logic signed [PW-1:0] k1_shift;
  logic signed [CW-1:0] k1_nxt;
  logic signed [CW-1:0] out_k1_r;
  logic signed [CW-1:0] out_k2_r;
  logic signed [CW-1:0] out_c1_r;

  always_comb begin
    k1_shift = m_prod_r >>> COEF_FRAC_BITS;
    if (k1_shift > K1_MAX) begin
      k1_nxt = cap_pkg::COEF_MAX;
    end else if (k1_shift < K1_MIN) begin
      k1_nxt = cap_pkg::COEF_MIN;
    end else begin
      k1_nxt = k1_shift[CW-1:0];
    end
  end

  // hold while the receiver stalls, otherwise take whatever the last stage has
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      out_k1_r <= k1_nxt;
      out_k2_r <= m_k2_r;
      out_c1_r <= m_c1_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_second_order_k1 = out_k1_r;
  assign out_second_order_k2 = out_k2_r;
  assign out_first_order_k1  = out_c1_r;

endmodule

`default_nettype wire

>>> hw/rtl/cap_chk.sv
// Port-level checker for crossover_allpass_coef, bound to the top level below.
// Depends only on the top level's ports.
`default_nettype none

module cap_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] out_second_order_k1,
  input wire [31:0] out_second_order_k2,
  input wire [31:0] out_first_order_k1
);

  // a stalled result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_second_order_k1)
      && $stable(out_second_order_k2) && $stable(out_first_order_k1))
    else $error("result changed or vanished while stalled");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input back-pressure only comes from a held result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready dropped without an output stall");

  // k2 is a negated, saturated value and never reaches the most negative code
  a_k2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_second_order_k2 != 32'h8000_0000)
    else $error("second-order k2 not saturated");

endmodule

bind crossover_allpass_coef cap_chk u_cap_chk (.*);

`default_nettype wire
